/* rtl/fpte_pkg.sv */
// shared types, constants and helpers of the four-level page table engine
// no dependencies; every other file of the block but fpte_if.sv imports this package
package fpte_pkg;

  localparam int TABLE_FRAMES      = 32;
  localparam int ENTRIES_PER_TABLE = 512;
  localparam int IDX_W             = $clog2(ENTRIES_PER_TABLE);
  localparam int FRAME_W           = $clog2(TABLE_FRAMES);
  localparam int USED_W            = $clog2(TABLE_FRAMES + 1);
  localparam int ADDR_W            = FRAME_W + IDX_W;
  localparam int MEM_DEPTH         = TABLE_FRAMES * ENTRIES_PER_TABLE;
  localparam int ENTRY_W           = 24;
  localparam int PFN_W             = 20;
  localparam int COUNT_W           = 10;
  localparam int VA_W              = 48;
  localparam int PA_W              = 32;
  localparam int PAGE_SHIFT        = 12;

  // entry layout: present, writable, user, no-execute, then frame or page number
  localparam int E_P     = 0;
  localparam int E_W     = 1;
  localparam int E_U     = 2;
  localparam int E_NX    = 3;
  localparam int E_SHIFT = 4;

  localparam logic [FRAME_W-1:0] TOP_FRAME      = FRAME_W'(0);
  localparam logic [FRAME_W-1:0] FIRST_FREEABLE = FRAME_W'(2);

  typedef enum logic [1:0] {
    CMD_MAP    = 2'd0,
    CMD_UNMAP  = 2'd1,
    CMD_UPDATE = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_ARG     = 3'd1,
    ST_ALREADY     = 3'd2,
    ST_NOT_PRESENT = 3'd3,
    ST_NO_SPACE    = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_READ,
    S_EVAL,
    S_DECIDE,
    S_ALLOC,
    S_LEAF,
    S_FREE,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_CLEAR,
    WR_TABLE,
    WR_LEAF_MAP,
    WR_LEAF_ZERO,
    WR_LEAF_UPD,
    WR_PARENT_ZERO
  } wr_kind_t;

  typedef struct packed {
    logic     idle;
    logic     rd_en;
    logic     capture;
    wr_kind_t wr;
    logic [1:0] lvl;
    logic     out_load;
    status_t  out_status;
    logic     query_ok;
  } ctl_t;

  typedef struct packed {
    cmd_t cmd;
    logic req_valid;
    logic arg_ok;
    logic rd_present;
    logic leaf_pu;
    logic user_all;
    logic enough;
    logic child_empty;
    logic clear_last;
    logic out_busy;
  } sts_t;

  function automatic logic [IDX_W-1:0] level_idx(input logic [VA_W-1:0] va,
                                                 input logic [1:0] lvl);
    logic [IDX_W-1:0] r;
    unique case (lvl)
      2'd0:    r = va[PAGE_SHIFT +: IDX_W];
      2'd1:    r = va[PAGE_SHIFT + IDX_W +: IDX_W];
      2'd2:    r = va[PAGE_SHIFT + 2*IDX_W +: IDX_W];
      default: r = va[PAGE_SHIFT + 3*IDX_W +: IDX_W];
    endcase
    return r;
  endfunction

endpackage

/* rtl/fpte_if.sv */
// request and response channel interfaces of the page table engine
// plain valid/ready channels; no package dependency
interface fpte_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [47:0] vaddr;
  logic [31:0] paddr;
  logic [2:0]  perm_flags;

  modport source (output valid, cmd, vaddr, paddr, perm_flags,
                  input ready);
  modport sink (input valid, cmd, vaddr, paddr, perm_flags,
                output ready);
endinterface

interface fpte_resp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic       can_write;
  logic       can_execute;

  modport source (output valid, status, can_write, can_execute, input ready);
  modport sink (input valid, status, can_write, can_execute, output ready);
endinterface

/* rtl/four_level_page_table_engine.sv */
// four-level page table engine: one user address space kept in a pool of table frames
// requests carry cmd (map, unmap, update flags, query), virtual and physical address
// and permission flags; every request gives exactly one response with status,
// can_write and can_execute. both channels are valid/ready; an item moves when
// both are high. one request is worked on at a time.
// a bad argument is answered straight from the check; every other item walks the
// table memory with dependent reads (read, then evaluate, per level) until an entry
// is missing or the leaf is reached, then writes one entry per new table (a map can
// build up to three), the leaf entry for a map, unmap or update, and one parent entry
// per released table (an unmap can release up to three); a query or a refused item
// writes nothing.
// the next request can be taken in the cycle after the response is loaded.
// after reset the table memory is cleared, all 16384 entries at one entry a cycle; ready
// stays low until that pass ends. the response sits in an output register: a new
// request is taken while the previous response waits, but the engine holds its
// next response until the receiver has taken the old one.
// depends on fpte_pkg, fpte_if, fpte_ctrl and fpte_datapath
module four_level_page_table_engine (
  input logic         clk,
  input logic         rst,
  fpte_req_if.sink    req,
  fpte_resp_if.source resp
);
  import fpte_pkg::*;

  ctl_t ctl;
  sts_t sts;

  fpte_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .ctl (ctl)
  );

  fpte_datapath u_dp (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .sts  (sts),
    .req  (req),
    .resp (resp)
  );

  // a response is only loaded into a free output register
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    ctl.out_load |-> !(resp.valid && !resp.ready))
    else $error("response loaded over one still waiting");

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("second item accepted while busy");

  // no item is taken during the clearing pass
  a_clear_closed: assert property (@(posedge clk) disable iff (rst)
    (ctl.wr == WR_CLEAR) |-> !req.ready)
    else $error("item accepted during memory clear");

  // an accepted item never answers in the next cycle
  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !ctl.out_load)
    else $error("response loaded right after accept");

endmodule

/* rtl/fpte_datapath.sv */
// datapath: table memory, frame pool, per-frame present counts, item and result registers
// depends on fpte_pkg and the channel interfaces in fpte_if.sv
module fpte_datapath (
  input  logic          clk,
  input  logic          rst,
  input  fpte_pkg::ctl_t ctl,
  output fpte_pkg::sts_t sts,
  fpte_req_if.sink      req,
  fpte_resp_if.source   resp
);
  import fpte_pkg::*;

  logic [ENTRY_W-1:0]  mem [0:MEM_DEPTH-1];
  logic [ENTRY_W-1:0]  rd_data;
  logic [ADDR_W-1:0]   rd_addr;
  logic [ADDR_W-1:0]   wr_addr;
  logic [ENTRY_W-1:0]  wr_data;
  logic                we;

  cmd_t                cmd_q;
  logic [VA_W-1:0]     va_q;
  logic [PA_W-1:0]     pa_q;
  logic [2:0]          pf_q;
  logic [FRAME_W-1:0]  frame_q [0:3];
  logic [ENTRY_W-1:0]  leaf_q;
  logic                user_all_q;

  logic [ADDR_W-1:0]   clr_cnt;
  logic [TABLE_FRAMES-1:0] in_use;
  logic [USED_W-1:0]   used;
  logic [COUNT_W-1:0]  cnt [0:TABLE_FRAMES-1];

  logic                resp_valid;
  logic                load;
  logic [1:0]          lvl_up;
  logic [1:0]          lvl_dn;
  logic [FRAME_W-1:0]  free_frame;
  logic [USED_W-1:0]   avail;
  logic [FRAME_W-1:0]  cur_frame;
  logic [FRAME_W-1:0]  par_frame;

  assign load      = ctl.idle && req.valid;
  assign req.ready = ctl.idle;
  assign lvl_up    = ctl.lvl + 2'd1;
  assign lvl_dn    = ctl.lvl - 2'd1;
  assign cur_frame = frame_q[ctl.lvl];
  assign par_frame = frame_q[lvl_up];

  // lowest free frame
  always_comb begin
    free_frame = TOP_FRAME;
    for (int i = TABLE_FRAMES - 1; i >= 0; i--) begin
      if (!in_use[i]) free_frame = FRAME_W'(i);
    end
  end

  assign avail = (used >= USED_W'(TABLE_FRAMES)) ? '0 : USED_W'(TABLE_FRAMES) - used;
  assign rd_addr = {cur_frame, level_idx(va_q, ctl.lvl)};

  always_comb begin
    wr_addr = {frame_q[0], level_idx(va_q, 2'd0)};
    wr_data = '0;
    unique case (ctl.wr)
      WR_NONE:      wr_addr = clr_cnt;
      WR_CLEAR:     wr_addr = clr_cnt;
      WR_TABLE: begin
        wr_addr = {cur_frame, level_idx(va_q, ctl.lvl)};
        wr_data = {(PFN_W - FRAME_W)'(0), free_frame, 1'b0, pf_q[1], 1'b1, 1'b1};
      end
      WR_LEAF_MAP:  wr_data = {pa_q[PA_W-1:PAGE_SHIFT], ~pf_q[2], pf_q[1], pf_q[0], 1'b1};
      WR_LEAF_ZERO: wr_data = '0;
      WR_LEAF_UPD:  wr_data = {leaf_q[ENTRY_W-1:E_SHIFT], ~pf_q[2], 1'b1, pf_q[0], 1'b1};
      WR_PARENT_ZERO: wr_addr = {par_frame, level_idx(va_q, lvl_up)};
      default:      wr_addr = clr_cnt;
    endcase
  end

  assign we = (ctl.wr != WR_NONE);

  always_ff @(posedge clk) begin
    if (we) mem[wr_addr] <= wr_data;
    if (ctl.rd_en) rd_data <= mem[rd_addr];
  end

  // item registers and walk results
  always_ff @(posedge clk) begin
    if (load) begin
      cmd_q      <= cmd_t'(req.cmd);
      va_q       <= req.vaddr;
      pa_q       <= req.paddr;
      pf_q       <= req.perm_flags;
      frame_q[3] <= TOP_FRAME;
      user_all_q <= 1'b1;
    end
    if (ctl.capture) begin
      user_all_q <= user_all_q & rd_data[E_U];
      if (ctl.lvl == 2'd0) leaf_q <= rd_data;
      else frame_q[lvl_dn] <= rd_data[E_SHIFT +: FRAME_W];
    end
    if (ctl.wr == WR_TABLE) frame_q[lvl_dn] <= free_frame;
  end

  // frame pool and present counts
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      in_use  <= TABLE_FRAMES'(3);
      used    <= USED_W'(2);
      for (int i = 0; i < TABLE_FRAMES; i++) cnt[i] <= '0;
    end else begin
      unique case (ctl.wr)
        WR_CLEAR: clr_cnt <= clr_cnt + 1'b1;
        WR_TABLE: begin
          in_use[free_frame] <= 1'b1;
          used               <= used + 1'b1;
          cnt[cur_frame]     <= cnt[cur_frame] + 1'b1;
        end
        WR_LEAF_MAP: cnt[frame_q[0]] <= cnt[frame_q[0]] + 1'b1;
        WR_LEAF_ZERO: begin
          if (cnt[frame_q[0]] != '0) cnt[frame_q[0]] <= cnt[frame_q[0]] - 1'b1;
        end
        WR_PARENT_ZERO: begin
          if (in_use[cur_frame]) begin
            in_use[cur_frame] <= 1'b0;
            if (used != '0) used <= used - 1'b1;
          end
          if (cnt[par_frame] != '0) cnt[par_frame] <= cnt[par_frame] - 1'b1;
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      resp_valid <= 1'b0;
    end else if (ctl.out_load) begin
      resp_valid <= 1'b1;
    end else if (resp.ready) begin
      resp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      resp.status      <= ctl.out_status;
      resp.can_write   <= ctl.query_ok & leaf_q[E_W];
      resp.can_execute <= ctl.query_ok & ~leaf_q[E_NX];
    end
  end

  assign resp.valid = resp_valid;

  assign sts.cmd         = cmd_q;
  assign sts.req_valid   = req.valid;
  assign sts.arg_ok      = (va_q[PAGE_SHIFT-1:0] == '0) && (va_q[VA_W-1:39] != '0) &&
                           ((cmd_q != CMD_MAP) || (pa_q[PAGE_SHIFT-1:0] == '0));
  assign sts.rd_present  = rd_data[E_P];
  assign sts.leaf_pu     = leaf_q[E_P] & leaf_q[E_U];
  assign sts.user_all    = user_all_q;
  assign sts.enough      = USED_W'(ctl.lvl) <= avail;
  assign sts.child_empty = (cnt[cur_frame] == '0) && (cur_frame >= FIRST_FREEABLE);
  assign sts.clear_last  = (clr_cnt == ADDR_W'(MEM_DEPTH - 1));
  assign sts.out_busy    = resp_valid && !resp.ready;

endmodule

/* rtl/fpte_ctrl.sv */
// controller: sequences the walk, allocation, leaf write and release of empty tables
// depends on fpte_pkg; talks to the datapath through ctl_t and sts_t only
module fpte_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  fpte_pkg::sts_t sts,
  output fpte_pkg::ctl_t ctl
);
  import fpte_pkg::*;

  state_t     state, state_next;
  logic [1:0] lvl, lvl_next;
  logic       missing, missing_next;
  status_t    stat, stat_next;
  logic       qok, qok_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      lvl     <= 2'd3;
      missing <= 1'b0;
      stat    <= ST_OK;
      qok     <= 1'b0;
    end else begin
      state   <= state_next;
      lvl     <= lvl_next;
      missing <= missing_next;
      stat    <= stat_next;
      qok     <= qok_next;
    end
  end

  always_comb begin
    state_next   = state;
    lvl_next     = lvl;
    missing_next = missing;
    stat_next    = stat;
    qok_next     = qok;
    ctl          = '0;
    ctl.wr       = WR_NONE;
    ctl.lvl      = lvl;
    ctl.out_status = stat;
    ctl.query_ok = qok;
    unique case (state)
      S_CLEAR: begin
        ctl.wr = WR_CLEAR;
        if (sts.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        ctl.idle = 1'b1;
        if (sts.req_valid) state_next = S_CHECK;
      end
      S_CHECK: begin
        qok_next = 1'b0;
        if (!sts.arg_ok) begin
          stat_next  = ST_BAD_ARG;
          state_next = S_DONE;
        end else begin
          lvl_next   = 2'd3;
          state_next = S_READ;
        end
      end
      S_READ: begin
        ctl.rd_en  = 1'b1;
        state_next = S_EVAL;
      end
      S_EVAL: begin
        ctl.capture = 1'b1;
        if (!sts.rd_present) begin
          missing_next = 1'b1;
          state_next   = S_DECIDE;
        end else if (lvl == 2'd0) begin
          missing_next = 1'b0;
          state_next   = S_DECIDE;
        end else begin
          lvl_next   = lvl - 2'd1;
          state_next = S_READ;
        end
      end
      S_DECIDE: begin
        state_next = S_DONE;
        stat_next  = ST_NOT_PRESENT;
        unique case (sts.cmd)
          CMD_MAP: begin
            if (!missing) stat_next = ST_ALREADY;
            else if (!sts.enough) stat_next = ST_NO_SPACE;
            else if (lvl == 2'd0) state_next = S_LEAF;
            else state_next = S_ALLOC;
          end
          CMD_UNMAP: begin
            if (!missing) state_next = S_LEAF;
          end
          CMD_UPDATE: begin
            if (!missing && sts.leaf_pu) state_next = S_LEAF;
          end
          CMD_QUERY: begin
            if (!missing && sts.user_all) begin
              stat_next = ST_OK;
              qok_next  = 1'b1;
            end
          end
          default: ;
        endcase
      end
      S_ALLOC: begin
        // one new table per cycle, walking down towards the leaf table
        ctl.wr   = WR_TABLE;
        lvl_next = lvl - 2'd1;
        if (lvl == 2'd1) state_next = S_LEAF;
      end
      S_LEAF: begin
        stat_next  = ST_OK;
        state_next = S_DONE;
        unique case (sts.cmd)
          CMD_MAP:    ctl.wr = WR_LEAF_MAP;
          CMD_UPDATE: ctl.wr = WR_LEAF_UPD;
          CMD_UNMAP: begin
            ctl.wr     = WR_LEAF_ZERO;
            lvl_next   = 2'd0;
            state_next = S_FREE;
          end
          default: ctl.wr = WR_NONE;
        endcase
      end
      S_FREE: begin
        // release empty tables up the chain, clearing the parent entry each time
        if (sts.child_empty) begin
          ctl.wr = WR_PARENT_ZERO;
          if (lvl == 2'd2) state_next = S_DONE;
          else lvl_next = lvl + 2'd1;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          ctl.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
